[design/sps_pkg.sv]
package sps_pkg;

	// fixed field widths of the request and response beats
	localparam int OP_W      = 2;
	localparam int ID_W      = 8;
	localparam int PAY_W     = 32;
	localparam int ST_W      = 2;
	localparam int CNT_W     = 9;
	localparam int PAY_EXT_W = 64;

	// default configuration of the set
	localparam int MAX_IDS_DEF      = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_ITER   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE    = 2'd0,
		ST_RANGE   = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

endpackage

[design/sps_if.sv]
// request channel: one operation per beat
interface sps_req_if;
	import sps_pkg::*;

	logic             valid;
	logic             ready;
	op_t              op;
	logic [ID_W-1:0]  element_id;
	logic [PAY_W-1:0] payload_in;

	modport source (output valid, output op, output element_id, output payload_in,
		input ready);
	modport sink (input valid, input op, input element_id, input payload_in,
		output ready);
endinterface

// response channel: one result per beat
interface sps_rsp_if;
	import sps_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic             found;
	logic [ID_W-1:0]  member_id;
	logic [PAY_W-1:0] payload_out;
	logic [CNT_W-1:0] member_count;
	logic             last;

	modport source (output valid, output status, output found, output member_id,
		output payload_out, output member_count, output last, input ready);
	modport sink (input valid, input status, input found, input member_id,
		input payload_out, input member_count, input last, output ready);
endinterface

[design/sparse_set_with_payload_core.sv]
// Sparse set of ids below MAX_IDS, each with a PAYLOAD_BITS payload word (wider payloads
// are kept to their low PAYLOAD_BITS bits). The block takes one request at a time and
// drives one registered response beat for add, remove and lookup, or one beat per member
// for iterate (one done beat if the set is empty). Every step of the sequencer waits on
// one registered read of the slot, id or payload RAM. An out-of-range id or an iterate of
// an empty set goes straight to its response; add, lookup and remove read the slot RAM,
// then the id and payload RAMs, and a remove of a member reads the last dense slot before
// moving it. The next request is taken as soon as the sequencer is back to idle, while
// the last response may still wait to be taken. After reset the set is empty at once:
// there is no clearing pass over the RAMs.
module sparse_set_with_payload_core #(
	parameter int MAX_IDS      = sps_pkg::MAX_IDS_DEF,
	parameter int PAYLOAD_BITS = sps_pkg::PAYLOAD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sps_req_if.sink   req,
	sps_rsp_if.source rsp
);
	import sps_pkg::*;

	localparam int SW = $clog2(MAX_IDS);
	localparam int CW = $clog2(MAX_IDS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_QUICK = 7'b0000010,
		S_SLOT  = 7'b0000100,
		S_CHK   = 7'b0001000,
		S_MOVE  = 7'b0010000,
		S_ITLD  = 7'b0100000,
		S_ITER  = 7'b1000000
	} state_t;

	state_t                  state_q, state_d;
	op_t                     op_q;
	logic [SW-1:0]           id_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [SW-1:0]           s_q;
	logic                    hit_q;
	logic [SW-1:0]           k_q;
	logic [CW-1:0]           count_q;
	logic [MAX_IDS-1:0]      seen_q;

	// ram ports
	logic                    slot_we, id_we, pay_we;
	logic [SW-1:0]           slot_waddr, slot_wdata, slot_raddr, slot_rdata;
	logic [SW-1:0]           id_waddr, id_wdata, id_raddr, id_rdata;
	logic [SW-1:0]           pay_waddr;
	logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;

	// result register
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_found_q;
	logic [ID_W-1:0]  out_id_q;
	logic [PAY_W-1:0] out_pay_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	logic             out_free, emit;
	status_t          res_status;
	logic             res_found;
	logic [ID_W-1:0]  res_id;
	logic [PAY_W-1:0] res_pay;
	logic [CNT_W-1:0] res_cnt;
	logic             res_last;

	logic                 accept, in_range, member, slot_hit, can_add, iter_last;
	logic [CW-1:0]        last_slot, k_next;
	logic [PAY_EXT_W-1:0] pay_ext;
	logic                 cnt_inc, cnt_dec, seen_set, k_clr, k_inc;

	sps_ram #(.WIDTH(SW), .DEPTH(MAX_IDS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	sps_ram #(.WIDTH(SW), .DEPTH(MAX_IDS)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
		.raddr(id_raddr), .rdata(id_rdata)
	);

	sps_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MAX_IDS)) u_pay_ram (
		.clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
		.raddr(id_raddr), .rdata(pay_rdata)
	);

	// handshake and shared lookups
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign in_range  = ({1'b0, req.element_id} < 9'(MAX_IDS));
	assign slot_hit  = seen_q[id_q] && (CW'(slot_rdata) < count_q);
	assign member    = hit_q && (id_rdata == id_q);
	assign can_add   = (count_q < CW'(MAX_IDS));
	assign last_slot = count_q - CW'(1);
	assign k_next    = CW'(k_q) + CW'(1);
	assign iter_last = (k_next == count_q);
	assign pay_ext   = PAY_EXT_W'(pay_rdata);

	// slot ram is read at the requested id
	assign slot_raddr = (state_q == S_IDLE) ? req.element_id[SW-1:0] : id_q;

	// sequencer, ram writes and result selection
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		res_status = ST_DONE;
		res_found  = 1'b0;
		res_id     = '0;
		res_pay    = '0;
		res_cnt    = CNT_W'(count_q);
		res_last   = 1'b1;
		id_raddr   = s_q;
		slot_we    = 1'b0;
		slot_waddr = id_q;
		slot_wdata = count_q[SW-1:0];
		id_we      = 1'b0;
		id_waddr   = count_q[SW-1:0];
		id_wdata   = id_q;
		pay_we     = 1'b0;
		pay_waddr  = count_q[SW-1:0];
		pay_wdata  = pay_q;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		seen_set   = 1'b0;
		k_clr      = 1'b0;
		k_inc      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_ITER) begin
						state_d = (count_q == '0) ? S_QUICK : S_ITLD;
					end else begin
						state_d = in_range ? S_SLOT : S_QUICK;
					end
				end
			end
			S_QUICK: begin
				res_status = (op_q == OP_ITER) ? ST_DONE : ST_RANGE;
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SLOT: begin
				id_raddr = slot_rdata;
				state_d  = S_CHK;
			end
			S_CHK: begin
				id_raddr = (op_q == OP_REMOVE) ? last_slot[SW-1:0] : s_q;
				case (op_q)
					OP_ADD: begin
						if (member) begin
							res_status = ST_PRESENT;
						end else if (can_add) begin
							res_cnt = CNT_W'(count_q) + CNT_W'(1);
						end
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (!member && can_add) begin
								slot_we  = 1'b1;
								id_we    = 1'b1;
								pay_we   = 1'b1;
								cnt_inc  = 1'b1;
								seen_set = 1'b1;
							end
						end
					end
					OP_REMOVE: begin
						res_status = ST_ABSENT;
						if (member) begin
							state_d = S_MOVE;
						end else if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						if (member) begin
							res_found = 1'b1;
							res_id    = ID_W'(id_q);
							res_pay   = pay_ext[PAY_W-1:0];
						end else begin
							res_status = ST_ABSENT;
						end
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_MOVE: begin
				// last dense entry moves into the freed slot
				id_raddr   = last_slot[SW-1:0];
				res_cnt    = CNT_W'(last_slot);
				slot_waddr = id_rdata;
				slot_wdata = s_q;
				id_waddr   = s_q;
				id_wdata   = id_rdata;
				pay_waddr  = s_q;
				pay_wdata  = pay_rdata;
				if (out_free) begin
					emit    = 1'b1;
					slot_we = 1'b1;
					id_we   = 1'b1;
					pay_we  = 1'b1;
					cnt_dec = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ITLD: begin
				id_raddr = '0;
				k_clr    = 1'b1;
				state_d  = S_ITER;
			end
			S_ITER: begin
				res_found = 1'b1;
				res_id    = ID_W'(id_rdata);
				res_pay   = pay_ext[PAY_W-1:0];
				res_last  = iter_last;
				id_raddr  = out_free ? k_next[SW-1:0] : k_q;
				if (out_free) begin
					emit  = 1'b1;
					k_inc = 1'b1;
					if (iter_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= last_slot;
			end
			if (seen_set) begin
				seen_q[id_q] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, slot pointers and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			id_q  <= req.element_id[SW-1:0];
			pay_q <= PAYLOAD_BITS'(PAY_EXT_W'(req.payload_in));
		end
		if (state_q == S_SLOT) begin
			s_q   <= slot_rdata;
			hit_q <= slot_hit;
		end
		if (k_clr) begin
			k_q <= '0;
		end else if (k_inc) begin
			k_q <= k_next[SW-1:0];
		end
		if (emit) begin
			out_status_q <= res_status;
			out_found_q  <= res_found;
			out_id_q     <= res_id;
			out_pay_q    <= res_pay;
			out_cnt_q    <= res_cnt;
			out_last_q   <= res_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found        = out_found_q;
	assign rsp.member_id    = out_id_q;
	assign rsp.payload_out  = out_pay_q;
	assign rsp.member_count = out_cnt_q;
	assign rsp.last         = out_last_q;

	// member count stays within the set size
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_IDS))
		else $error("member count above set size");

	// member count moves by at most one per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
		(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("member count jumped");

	// iteration cursor never passes the dense list
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ITER |-> CW'(k_q) < count_q)
		else $error("iteration past last member");

	// a new result is only loaded once the previous one is gone
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");

	// a reported member always comes with a done status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_found_q |-> out_status_q == ST_DONE)
		else $error("member reported with error status");

endmodule

[design/sps_ram.sv]
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
